// File: rtl/core/fhm_pkg.sv
package fhm_pkg;

    // sizing of the waiter queue and thread ids
    localparam int WAIT_DEPTH = 16;
    localparam int ID_BITS    = 8;
    localparam int SLOT_W     = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int CNT_W      = $clog2(WAIT_DEPTH + 1);

    // request kinds
    localparam logic [1:0] KIND_LOCK   = 2'd0;
    localparam logic [1:0] KIND_TRY    = 2'd1;
    localparam logic [1:0] KIND_UNLOCK = 2'd2;

    // result status codes
    localparam logic [2:0] STAT_GRANTED = 3'd0;
    localparam logic [2:0] STAT_QUEUED  = 3'd1;
    localparam logic [2:0] STAT_REFUSED = 3'd2;
    localparam logic [2:0] STAT_FULL    = 3'd3;
    localparam logic [2:0] STAT_HANDOFF = 3'd4;
    localparam logic [2:0] STAT_FREED   = 3'd5;
    localparam logic [2:0] STAT_IGNORED = 3'd6;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_EXEC,
        FSM_OUT
    } fsm_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
    } fhm_cmd_t;

endpackage

// File: rtl/core/fhm_ctrl.sv
module fhm_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    output fhm_pkg::fhm_cmd_t cmd
);

    fhm_pkg::fsm_state_t state_reg;
    fhm_pkg::fsm_state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fhm_pkg::FSM_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and handshake outputs
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        cmd.load   = 1'b0;
        cmd.exec   = 1'b0;
        unique case (state_reg)
            fhm_pkg::FSM_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid) begin
                    state_next = fhm_pkg::FSM_EXEC;
                end
            end
            fhm_pkg::FSM_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = fhm_pkg::FSM_OUT;
            end
            fhm_pkg::FSM_OUT: begin
                m_valid = 1'b1;
                s_ready = m_ready;
                if (m_ready) begin
                    cmd.load   = s_valid;
                    state_next = s_valid ? fhm_pkg::FSM_EXEC : fhm_pkg::FSM_IDLE;
                end
            end
            default: begin
                state_next = fhm_pkg::FSM_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/fhm_datapath.sv
module fhm_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  fhm_pkg::fhm_cmd_t cmd,
    input  logic [1:0]        s_kind,
    input  logic [7:0]        s_thread_id,
    output logic [2:0]        m_status,
    output logic              m_woken_valid,
    output logic [7:0]        m_woken_thread,
    output logic              m_owner_valid,
    output logic [7:0]        m_owner_thread
);

    localparam int IW = fhm_pkg::ID_BITS;
    localparam int SW = fhm_pkg::SLOT_W;
    localparam int CW = fhm_pkg::CNT_W;

    // captured request
    logic [1:0]    kind_reg;
    logic [IW-1:0] tid_reg;

    // lock state
    logic          held_reg, held_next;
    logic [IW-1:0] holder_reg, holder_next;
    logic [SW-1:0] rd_slot_reg, rd_slot_next;
    logic [SW-1:0] wr_slot_reg, wr_slot_next;
    logic [CW-1:0] count_reg, count_next;

    // waiter queue storage
    logic [IW-1:0] wait_mem [fhm_pkg::WAIT_DEPTH];
    logic [IW-1:0] rd_data_reg;
    logic          push;

    // result register
    logic [2:0]    status_reg, status_next;
    logic          woken_valid_reg, woken_valid_next;
    logic [IW-1:0] woken_reg, woken_next;

    function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
        return (s == SW'(fhm_pkg::WAIT_DEPTH - 1)) ? '0 : s + 1'b1;
    endfunction

    // request capture
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg <= s_kind;
            tid_reg  <= IW'(s_thread_id);
        end
    end

    // queue memory, registered read at the head slot
    always_ff @(posedge aclk) begin
        if (push) begin
            wait_mem[wr_slot_reg] <= tid_reg;
        end
        rd_data_reg <= wait_mem[rd_slot_reg];
    end

    // request decode
    always_comb begin
        held_next        = held_reg;
        holder_next      = holder_reg;
        rd_slot_next     = rd_slot_reg;
        wr_slot_next     = wr_slot_reg;
        count_next       = count_reg;
        push             = 1'b0;
        status_next      = fhm_pkg::STAT_IGNORED;
        woken_valid_next = 1'b0;
        woken_next       = '0;
        if (cmd.exec) begin
            unique case (kind_reg)
                fhm_pkg::KIND_LOCK: begin
                    if (!held_reg) begin
                        held_next   = 1'b1;
                        holder_next = tid_reg;
                        status_next = fhm_pkg::STAT_GRANTED;
                    end else if (count_reg == CW'(fhm_pkg::WAIT_DEPTH)) begin
                        status_next = fhm_pkg::STAT_FULL;
                    end else begin
                        push         = 1'b1;
                        wr_slot_next = slot_inc(wr_slot_reg);
                        count_next   = count_reg + 1'b1;
                        status_next  = fhm_pkg::STAT_QUEUED;
                    end
                end
                fhm_pkg::KIND_TRY: begin
                    if (!held_reg) begin
                        held_next   = 1'b1;
                        holder_next = tid_reg;
                        status_next = fhm_pkg::STAT_GRANTED;
                    end else begin
                        status_next = fhm_pkg::STAT_REFUSED;
                    end
                end
                fhm_pkg::KIND_UNLOCK: begin
                    if (!held_reg) begin
                        status_next = fhm_pkg::STAT_IGNORED;
                    end else if (count_reg != '0) begin
                        rd_slot_next     = slot_inc(rd_slot_reg);
                        count_next       = count_reg - 1'b1;
                        holder_next      = rd_data_reg;
                        woken_valid_next = 1'b1;
                        woken_next       = rd_data_reg;
                        status_next      = fhm_pkg::STAT_HANDOFF;
                    end else begin
                        held_next   = 1'b0;
                        holder_next = '0;
                        status_next = fhm_pkg::STAT_FREED;
                    end
                end
                default: begin
                    status_next = fhm_pkg::STAT_IGNORED;
                end
            endcase
        end
    end

    // lock state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg    <= 1'b0;
            holder_reg  <= '0;
            rd_slot_reg <= '0;
            wr_slot_reg <= '0;
            count_reg   <= '0;
        end else begin
            held_reg    <= held_next;
            holder_reg  <= holder_next;
            rd_slot_reg <= rd_slot_next;
            wr_slot_reg <= wr_slot_next;
            count_reg   <= count_next;
        end
    end

    // result registers, loaded when the item executes
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            status_reg      <= status_next;
            woken_valid_reg <= woken_valid_next;
            woken_reg       <= woken_next;
        end
    end

    assign m_status       = status_reg;
    assign m_woken_valid  = woken_valid_reg;
    assign m_woken_thread = 8'(woken_reg);
    assign m_owner_valid  = held_reg;
    assign m_owner_thread = 8'(holder_reg);

endmodule

// File: rtl/core/fifo_handoff_mutex.sv
// a result item is offered in the OUT state once its request has been
// captured and then executed in the EXEC state
// a new request is taken only while idle or as the pending result is
// taken; each is captured, then executed against the registered queue head
// reset: synchronous active-low aresetn frees the lock and empties the queue;
// queue entries are not cleared, and no clearing pass is needed
module fifo_handoff_mutex (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_kind,
    input  logic [7:0] s_thread_id,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_status,
    output logic       m_woken_valid,
    output logic [7:0] m_woken_thread,
    output logic       m_owner_valid,
    output logic [7:0] m_owner_thread
);

    fhm_pkg::fhm_cmd_t cmd;

    // sequencing
    fhm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // lock state and waiter queue
    fhm_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .s_kind         (s_kind),
        .s_thread_id    (s_thread_id),
        .m_status       (m_status),
        .m_woken_valid  (m_woken_valid),
        .m_woken_thread (m_woken_thread),
        .m_owner_valid  (m_owner_valid),
        .m_owner_thread (m_owner_thread)
    );

endmodule

// File: rtl/core/fhm_checker.sv
module fhm_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [1:0] s_kind,
    input logic [7:0] s_thread_id,
    input logic       m_valid,
    input logic       m_ready,
    input logic [2:0] m_status,
    input logic       m_woken_valid,
    input logic [7:0] m_woken_thread,
    input logic       m_owner_valid,
    input logic [7:0] m_owner_thread
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status)
            && $stable(m_owner_thread) && $stable(m_woken_thread))
        else $error("result item changed while stalled");

    // a woken thread only comes with a handoff
    a_woken_handoff: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_woken_valid == (m_status == fhm_pkg::STAT_HANDOFF)))
        else $error("woken flag does not match handoff status");

    // no woken id without a handoff
    a_woken_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_woken_valid |-> m_woken_thread == 8'd0)
        else $error("woken id set without a handoff");

    // a free lock reports owner zero
    a_owner_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_owner_valid |-> m_owner_thread == 8'd0)
        else $error("free lock shows an owner");

    // held state agrees with status
    a_owner_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == fhm_pkg::STAT_GRANTED || m_status == fhm_pkg::STAT_QUEUED
            || m_status == fhm_pkg::STAT_REFUSED || m_status == fhm_pkg::STAT_FULL
            || m_status == fhm_pkg::STAT_HANDOFF) |-> m_owner_valid)
        else $error("status implies a held lock but none is shown");

endmodule

bind fifo_handoff_mutex fhm_checker u_fhm_checker (.*);
